>>> hdl/i64dec_pkg.sv
// Shared types and constants for the signed 64-bit to decimal ASCII converter.
// No dependencies; every other file in hdl imports this package.
package i64dec_pkg;

    localparam int VALUE_W      = 64;
    localparam int CHAR_W       = 8;
    localparam int DIG_W        = 4;
    localparam int NUM_DIGITS   = 20;
    localparam int BCD_W        = NUM_DIGITS * DIG_W;
    localparam int BITS_PER_CYC = 4;
    localparam int CONV_CYCLES  = VALUE_W / BITS_PER_CYC;
    localparam int CONV_CNT_W   = $clog2(CONV_CYCLES);
    localparam int DIG_IDX_W    = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

>>> hdl/i64dec_front.sv
// Front end: accepts a signed value, splits it into sign and unsigned magnitude.
// Depends on i64dec_pkg; feeds i64dec_queue.
module i64dec_front
    import i64dec_pkg::*;
(
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_queue_status             i_q_status,
    output logic                      o_push,
    output t_job                      o_job
);

    logic [VALUE_W-1:0] w_bits;

    // The magnitude of the most negative value stays 2^63 in unsigned form.
    assign w_bits    = i_value;
    assign o_ready   = !i_q_status.full;
    assign o_push    = i_valid && !i_q_status.full;
    assign o_job.neg = w_bits[VALUE_W-1];
    assign o_job.mag = w_bits[VALUE_W-1] ? (~w_bits + {{(VALUE_W-1){1'b0}}, 1'b1}) : w_bits;

endmodule

>>> hdl/i64dec_queue.sv
// Two-entry queue of jobs between the front end and the back end.
// Depends on i64dec_pkg.
module i64dec_queue
    import i64dec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_job,
    output t_queue_status o_status
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_job           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> hdl/i64dec_back.sv
// Back end: shift-and-add-3 binary to BCD conversion, four bits per cycle,
// then emission of the sign and digits through an output register. Depends on i64dec_pkg.
module i64dec_back
    import i64dec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_queue_status     i_q_status,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_ascii_char,
    output logic              o_final_char
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_EMIT
    } t_state;

    t_state                r_state,     n_state;
    logic [BCD_W-1:0]      r_bcd,       n_bcd;
    logic [VALUE_W-1:0]    r_bin,       n_bin;
    logic [CONV_CNT_W-1:0] r_cnt,       n_cnt;
    logic                  r_neg,       n_neg;
    logic [DIG_IDX_W-1:0]  r_idx,       n_idx;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char,  n_out_char;
    logic                  r_out_final, n_out_final;

    logic [BCD_W-1:0]     w_bcd_step;
    logic [VALUE_W-1:0]   w_bin_step;
    logic [DIG_IDX_W-1:0] w_top_digit;
    logic [DIG_W-1:0]     w_digit;
    logic                 w_out_free;

    always_comb begin
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
        bcd = r_bcd;
        bin = r_bin;
        for (int s = 0; s < BITS_PER_CYC; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (bcd[d*DIG_W +: DIG_W] >= 4'd5) begin
                    bcd[d*DIG_W +: DIG_W] = bcd[d*DIG_W +: DIG_W] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bin[VALUE_W-1]};
            bin = {bin[VALUE_W-2:0], 1'b0};
        end
        w_bcd_step = bcd;
        w_bin_step = bin;
    end

    always_comb begin
        w_top_digit = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*DIG_W +: DIG_W] != '0) begin
                w_top_digit = DIG_IDX_W'(d);
            end
        end
    end

    assign w_digit    = r_bcd[r_idx*DIG_W +: DIG_W];
    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = (r_state == ST_IDLE) && !i_q_status.empty;

    always_comb begin
        n_state     = r_state;
        n_bcd       = r_bcd;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_final = r_out_final;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    n_bcd   = '0;
                    n_bin   = i_job.mag;
                    n_neg   = i_job.neg;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = w_bcd_step;
                n_bin = w_bin_step;
                n_cnt = r_cnt + CONV_CNT_W'(1);
                if (r_cnt == CONV_CNT_W'(CONV_CYCLES - 1)) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                n_idx   = w_top_digit;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_out_char  = ASCII_MINUS;
                        n_out_final = 1'b0;
                        n_neg       = 1'b0;
                    end else begin
                        n_out_char  = ASCII_ZERO + {{(CHAR_W-DIG_W){1'b0}}, w_digit};
                        n_out_final = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx - DIG_IDX_W'(1);
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bcd       <= n_bcd;
        r_bin       <= n_bin;
        r_cnt       <= n_cnt;
        r_neg       <= n_neg;
        r_idx       <= n_idx;
        r_out_char  <= n_out_char;
        r_out_final <= n_out_final;
    end

    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_out_char;
    assign o_final_char = r_out_final;

endmodule

>>> hdl/signed_int64_to_decimal_ascii.sv
// Top level of the signed 64-bit to decimal ASCII converter.
// Depends on i64dec_pkg, i64dec_front, i64dec_queue and i64dec_back.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------
//   input   | in        | i_valid / o_ready  | i_value (64-bit signed)
//   output  | out       | o_valid / i_ready  | o_ascii_char, o_final_char
//
// Each value is loaded from the queue, converted by the four-bit-per-cycle BCD
// converter and has its leading digit found, and then the back end emits it at one
// character per cycle while the output is not stalled (1 to 20 characters).
// The queue holds two values, so the input keeps accepting while the back end works, until it is full.
// Reset is synchronous, active low, and empties the queue and the output register.
// A stalled output holds its character and pauses emission until it is taken.
module signed_int64_to_decimal_ascii
    import i64dec_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [CHAR_W-1:0]         o_ascii_char,
    output logic                      o_final_char
);

    t_queue_status w_q_status;
    t_job          w_push_job;
    t_job          w_pop_job;
    logic          w_push;
    logic          w_pop;

    i64dec_front u_front (
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    i64dec_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_pop_job),
        .o_status (w_q_status)
    );

    i64dec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (w_q_status),
        .i_job        (w_pop_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_final_char (o_final_char)
    );

endmodule

>>> hdl/i64dec_chk.sv
// Port-level checker for the converter, bound to its top level.
// Depends on i64dec_pkg and signed_int64_to_decimal_ascii.
module i64dec_chk
    import i64dec_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CHAR_W-1:0] o_ascii_char,
    input logic              o_final_char
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ascii_char) && $stable(o_final_char))
        else $error("Stalled output beat changed.");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_char == ASCII_MINUS) ||
                    ((o_ascii_char >= ASCII_ZERO) && (o_ascii_char <= ASCII_ZERO + 8'd9)))
        else $error("Output character is neither a minus sign nor a digit.");

    a_minus_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_ascii_char == ASCII_MINUS) |-> !o_final_char)
        else $error("Minus sign ends a run.");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_final_char |=> o_valid && (o_ascii_char != ASCII_MINUS))
        else $error("Run did not continue with a digit in the next cycle.");

endmodule

bind signed_int64_to_decimal_ascii i64dec_chk u_i64dec_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_ascii_char (o_ascii_char),
    .o_final_char (o_final_char)
);
